// ----- sv/dcfp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcfp_pkg
// Shared constants, codes and the command record passed between the stages
// of the drive command frame parser.
// ----------------------------------------------------------------------------
package dcfp_pkg;

   localparam int FRAME_MAX_DEF = 256;
   localparam int HEAD_LEN      = 11;

   localparam logic [7:0] HDR_BYTE0    = 8'h66;
   localparam logic [7:0] HDR_BYTE1    = 8'hCC;
   localparam logic [7:0] ID_DRIVE     = 8'h01;
   localparam logic [7:0] ID_GAIN_SET  = 8'h05;
   localparam logic [7:0] ID_GAIN_READ = 8'h06;

   localparam logic [1:0] KIND_NONE      = 2'd0;
   localparam logic [1:0] KIND_DRIVE     = 2'd1;
   localparam logic [1:0] KIND_GAIN_SET  = 2'd2;
   localparam logic [1:0] KIND_GAIN_READ = 2'd3;

   localparam logic [16:0] WORD_OFFSET = 17'd30000;

   // angle scale 660/1230 reduces to 22/41
   localparam int          MAG_W      = 20;
   localparam int          QUOT_W     = 15;
   localparam int          RECIP_SHIFT = 24;
   localparam logic [18:0] RECIP_41   = 19'd409200;
   localparam logic [5:0]  DIV_41     = 6'd41;
   localparam logic [15:0] ANGLE_LIM  = 16'd42900;

   typedef struct packed {
      logic        valid;
      logic [1:0]  kind;
      logic [7:0]  enable;
      logic [16:0] speed;
      logic [7:0]  brake;
      logic [7:0]  sum_byte;
      logic [16:0] gain_p;
      logic [16:0] gain_i;
      logic [16:0] gain_d;
      logic        angle_neg;
   } cmd_type;

endpackage

// ----- sv/drive_command_frame_parser_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drive_command_frame_parser_core
// Parses 66 CC framed drive and gain commands, one received byte per request.
// ----------------------------------------------------------------------------
// One byte is taken every cycle. A request that ends a frame produces one
// response after passing the input register, frame check register, angle
// multiply register and response register; other bytes give no response.
// The four stages move together, so a stalled response holds the whole
// pipeline and req_stall follows rsp_stall while a response waits.
// The response carries the packet kind and all stored command and gain
// values, updated by the frame that caused it.
module drive_command_frame_parser_core
   import dcfp_pkg::*;
#(
   parameter int FRAME_MAX = FRAME_MAX_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic [7:0]   req_rx_byte,
   input  logic         req_frame_end,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic [1:0]   rsp_packet_kind,
   output logic [7:0]   rsp_drive_enable,
   output logic [16:0]  rsp_target_speed,
   output logic [16:0]  rsp_target_angle,
   output logic [7:0]   rsp_brake_value,
   output logic [7:0]   rsp_stored_sum_byte,
   output logic [16:0]  rsp_gain_p,
   output logic [16:0]  rsp_gain_i,
   output logic [16:0]  rsp_gain_d
);

   logic              advance;
   cmd_type           chk_cmd, ang_cmd;
   logic [MAG_W-1:0]  chk_mag;
   logic [16:0]       ang_value;

   assign advance   = !rsp_valid || !rsp_stall;
   assign req_stall = !advance;

   dcfp_frame_track #(
      .FRAME_MAX (FRAME_MAX)
   ) u_track (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .req_valid     (req_valid),
      .req_rx_byte   (req_rx_byte),
      .req_frame_end (req_frame_end),
      .cmd_out       (chk_cmd),
      .mag_out       (chk_mag)
   );

   dcfp_angle_scale u_angle (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .cmd_in    (chk_cmd),
      .mag_in    (chk_mag),
      .cmd_out   (ang_cmd),
      .angle_out (ang_value)
   );

   dcfp_store u_store (
      .clock               (clock),
      .reset               (reset),
      .advance             (advance),
      .cmd_in              (ang_cmd),
      .angle_in            (ang_value),
      .rsp_valid           (rsp_valid),
      .rsp_packet_kind     (rsp_packet_kind),
      .rsp_drive_enable    (rsp_drive_enable),
      .rsp_target_speed    (rsp_target_speed),
      .rsp_target_angle    (rsp_target_angle),
      .rsp_brake_value     (rsp_brake_value),
      .rsp_stored_sum_byte (rsp_stored_sum_byte),
      .rsp_gain_p          (rsp_gain_p),
      .rsp_gain_i          (rsp_gain_i),
      .rsp_gain_d          (rsp_gain_d)
   );

endmodule

// ----- sv/dcfp_frame_track.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcfp_frame_track
// Input register, per-frame tracking (index, running sum, header bytes,
// checksum byte) and the frame check that produces the command record.
// ----------------------------------------------------------------------------
module dcfp_frame_track
   import dcfp_pkg::*;
#(
   parameter int FRAME_MAX = FRAME_MAX_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic               req_valid,
   input  logic [7:0]         req_rx_byte,
   input  logic               req_frame_end,
   output cmd_type            cmd_out,
   output logic [MAG_W-1:0]   mag_out
);

   localparam int IDX_W = $clog2(FRAME_MAX + 1);
   localparam int CMP_W = (IDX_W >= 9) ? IDX_W + 1 : 10;

   logic              in_valid_ff;
   logic [7:0]        byte_ff;
   logic              last_ff;

   logic [IDX_W-1:0]  idx_ff, idx_in, idx_upd;
   logic [7:0]        sum_ff, sum_in, sum_upd;
   logic [7:0]        seen_ff, seen_in, seen_upd;
   logic              present_ff, present_in, present_upd;
   logic [7:0]        head_ff [HEAD_LEN];
   logic [7:0]        head_in [HEAD_LEN];

   cmd_type           cmd_ff, cmd_in;
   logic [MAG_W-1:0]  mag_ff, mag_in;

   logic              in_range;
   logic [7:0]        dlen;
   logic [CMP_W-1:0]  iw, dl3, dl4;
   logic              sum_hit, chk_hit;
   logic              frame_ok, long_frame;
   logic [16:0]       angle_word;
   logic [15:0]       angle_mag;

   always_comb begin
      in_range = idx_ff < IDX_W'(FRAME_MAX);
      dlen     = (idx_ff > IDX_W'(3)) ? head_ff[3] : 8'hFF;
      iw       = CMP_W'(idx_ff);
      dl3      = CMP_W'(dlen) + CMP_W'(3);
      dl4      = CMP_W'(dlen) + CMP_W'(4);
      sum_hit  = in_range && (iw == CMP_W'(2) || iw == CMP_W'(3) ||
                 (iw >= CMP_W'(4) && iw <= dl3));
      chk_hit  = in_range && !sum_hit && iw >= CMP_W'(4) && iw == dl4;

      for (int k = 0; k < HEAD_LEN; k++) begin
         head_in[k] = (in_range && idx_ff == IDX_W'(k)) ? byte_ff : head_ff[k];
      end
      sum_upd     = sum_hit ? sum_ff + byte_ff : sum_ff;
      seen_upd    = chk_hit ? byte_ff : seen_ff;
      present_upd = chk_hit | present_ff;
      idx_upd     = in_range ? idx_ff + IDX_W'(1) : idx_ff;

      // state cleared at every frame end
      if (last_ff) begin
         idx_in     = '0;
         sum_in     = '0;
         seen_in    = '0;
         present_in = 1'b0;
      end else begin
         idx_in     = idx_upd;
         sum_in     = sum_upd;
         seen_in    = seen_upd;
         present_in = present_upd;
      end

      frame_ok   = idx_upd >= IDX_W'(5) && head_in[0] == HDR_BYTE0 &&
                   head_in[1] == HDR_BYTE1 && present_upd && sum_upd == seen_upd;
      long_frame = idx_upd >= IDX_W'(HEAD_LEN);

      cmd_in.valid = in_valid_ff && last_ff;
      cmd_in.kind  = KIND_NONE;
      if (frame_ok) begin
         if (head_in[2] == ID_DRIVE && long_frame) begin
            cmd_in.kind = KIND_DRIVE;
         end else if (head_in[2] == ID_GAIN_SET && long_frame) begin
            cmd_in.kind = KIND_GAIN_SET;
         end else if (head_in[2] == ID_GAIN_READ) begin
            cmd_in.kind = KIND_GAIN_READ;
         end
      end
      cmd_in.enable   = head_in[4];
      cmd_in.speed    = {1'b0, head_in[5], head_in[6]} - WORD_OFFSET;
      cmd_in.brake    = head_in[9];
      cmd_in.sum_byte = head_in[10];
      cmd_in.gain_p   = {1'b0, head_in[4], head_in[5]} - WORD_OFFSET;
      cmd_in.gain_i   = {1'b0, head_in[6], head_in[7]} - WORD_OFFSET;
      cmd_in.gain_d   = {1'b0, head_in[8], head_in[9]} - WORD_OFFSET;

      angle_word       = {1'b0, head_in[7], head_in[8]} - WORD_OFFSET;
      cmd_in.angle_neg = angle_word[16];
      angle_mag        = angle_word[16] ? 16'(-angle_word) : angle_word[15:0];
      // magnitude times 22 as shift and add
      mag_in = (MAG_W'(angle_mag) << 4) + (MAG_W'(angle_mag) << 2) +
               (MAG_W'(angle_mag) << 1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         idx_ff       <= '0;
         sum_ff       <= '0;
         seen_ff      <= '0;
         present_ff   <= 1'b0;
         cmd_ff.valid <= 1'b0;
      end else if (advance) begin
         in_valid_ff  <= req_valid;
         cmd_ff.valid <= cmd_in.valid;
         if (in_valid_ff) begin
            idx_ff     <= idx_in;
            sum_ff     <= sum_in;
            seen_ff    <= seen_in;
            present_ff <= present_in;
         end
      end
      if (advance) begin
         byte_ff <= req_rx_byte;
         last_ff <= req_frame_end;
         if (in_valid_ff) begin
            for (int k = 0; k < HEAD_LEN; k++) begin
               head_ff[k] <= head_in[k];
            end
         end
         cmd_ff.kind      <= cmd_in.kind;
         cmd_ff.enable    <= cmd_in.enable;
         cmd_ff.speed     <= cmd_in.speed;
         cmd_ff.brake     <= cmd_in.brake;
         cmd_ff.sum_byte  <= cmd_in.sum_byte;
         cmd_ff.gain_p    <= cmd_in.gain_p;
         cmd_ff.gain_i    <= cmd_in.gain_i;
         cmd_ff.gain_d    <= cmd_in.gain_d;
         cmd_ff.angle_neg <= cmd_in.angle_neg;
         mag_ff           <= mag_in;
      end
   end

   assign cmd_out = cmd_ff;
   assign mag_out = mag_ff;

endmodule

// ----- sv/dcfp_angle_scale.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcfp_angle_scale
// Divides the scaled angle magnitude by 41 with a reciprocal multiply and a
// single correction step, then applies the x65 scale, clamp and sign.
// ----------------------------------------------------------------------------
module dcfp_angle_scale
   import dcfp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  cmd_type           cmd_in,
   input  logic [MAG_W-1:0]  mag_in,
   output cmd_type           cmd_out,
   output logic [16:0]       angle_out
);

   localparam int PROD_W = MAG_W + 19;

   cmd_type            cmd_ff;
   logic [MAG_W-1:0]   mag_ff;
   logic [QUOT_W-1:0]  quot_ff, quot_in;
   logic [PROD_W-1:0]  prod;

   logic [MAG_W-1:0]   rem;
   logic [QUOT_W-1:0]  quot;
   logic [20:0]        scaled;
   logic [15:0]        clamped;

   always_comb begin
      prod    = PROD_W'(mag_in) * PROD_W'(RECIP_41);
      quot_in = prod[RECIP_SHIFT +: QUOT_W];
   end

   // estimate is at most one low
   always_comb begin
      rem     = mag_ff - MAG_W'(quot_ff) * MAG_W'(DIV_41);
      quot    = (rem >= MAG_W'(DIV_41)) ? quot_ff + QUOT_W'(1) : quot_ff;
      scaled  = (21'(quot) << 6) + 21'(quot);
      clamped = (scaled > 21'(ANGLE_LIM)) ? ANGLE_LIM : scaled[15:0];
      angle_out = cmd_ff.angle_neg ? 17'(-{1'b0, clamped}) : {1'b0, clamped};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_ff.valid <= 1'b0;
      end else if (advance) begin
         cmd_ff.valid <= cmd_in.valid;
      end
      if (advance) begin
         cmd_ff.kind      <= cmd_in.kind;
         cmd_ff.enable    <= cmd_in.enable;
         cmd_ff.speed     <= cmd_in.speed;
         cmd_ff.brake     <= cmd_in.brake;
         cmd_ff.sum_byte  <= cmd_in.sum_byte;
         cmd_ff.gain_p    <= cmd_in.gain_p;
         cmd_ff.gain_i    <= cmd_in.gain_i;
         cmd_ff.gain_d    <= cmd_in.gain_d;
         cmd_ff.angle_neg <= cmd_in.angle_neg;
         mag_ff           <= mag_in;
         quot_ff          <= quot_in;
      end
   end

   assign cmd_out = cmd_ff;

endmodule

// ----- sv/dcfp_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcfp_store
// Stored drive command and gains; these registers double as the response
// register, together with the response valid and packet kind.
// ----------------------------------------------------------------------------
module dcfp_store
   import dcfp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         advance,
   input  cmd_type      cmd_in,
   input  logic [16:0]  angle_in,
   output logic         rsp_valid,
   output logic [1:0]   rsp_packet_kind,
   output logic [7:0]   rsp_drive_enable,
   output logic [16:0]  rsp_target_speed,
   output logic [16:0]  rsp_target_angle,
   output logic [7:0]   rsp_brake_value,
   output logic [7:0]   rsp_stored_sum_byte,
   output logic [16:0]  rsp_gain_p,
   output logic [16:0]  rsp_gain_i,
   output logic [16:0]  rsp_gain_d
);

   logic         valid_ff;
   logic [1:0]   kind_ff;
   logic [7:0]   enable_ff;
   logic [16:0]  speed_ff;
   logic [16:0]  angle_ff;
   logic [7:0]   brake_ff;
   logic [7:0]   sum_ff;
   logic [16:0]  gain_p_ff, gain_i_ff, gain_d_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         kind_ff   <= KIND_NONE;
         enable_ff <= '0;
         speed_ff  <= '0;
         angle_ff  <= '0;
         brake_ff  <= '0;
         sum_ff    <= '0;
         gain_p_ff <= '0;
         gain_i_ff <= '0;
         gain_d_ff <= '0;
      end else if (advance) begin
         valid_ff <= cmd_in.valid;
         if (cmd_in.valid) begin
            kind_ff <= cmd_in.kind;
            unique case (cmd_in.kind)
               KIND_DRIVE: begin
                  enable_ff <= cmd_in.enable;
                  speed_ff  <= cmd_in.speed;
                  angle_ff  <= angle_in;
                  brake_ff  <= cmd_in.brake;
                  sum_ff    <= cmd_in.sum_byte;
               end
               KIND_GAIN_SET: begin
                  gain_p_ff <= cmd_in.gain_p;
                  gain_i_ff <= cmd_in.gain_i;
                  gain_d_ff <= cmd_in.gain_d;
               end
               default: begin
               end
            endcase
         end
      end
   end

   assign rsp_valid           = valid_ff;
   assign rsp_packet_kind     = kind_ff;
   assign rsp_drive_enable    = enable_ff;
   assign rsp_target_speed    = speed_ff;
   assign rsp_target_angle    = angle_ff;
   assign rsp_brake_value     = brake_ff;
   assign rsp_stored_sum_byte = sum_ff;
   assign rsp_gain_p          = gain_p_ff;
   assign rsp_gain_i          = gain_i_ff;
   assign rsp_gain_d          = gain_d_ff;

endmodule

// ----- bench/dcfp_bench_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcfp_bench_pkg
// Status record and scoreboard for the drive command frame parser bench. The
// scoreboard follows the byte stream and predicts the status that each frame
// end reports, then matches the responses against those predictions in order.
// ----------------------------------------------------------------------------
package dcfp_bench_pkg;
   import dcfp_pkg::*;

   localparam int WORD_BIAS = 30000;
   localparam int ANGLE_NUM = 660;
   localparam int ANGLE_DEN = 1230;
   localparam int ANGLE_MUL = 65;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  enable;
      logic [16:0] speed;
      logic [16:0] angle;
      logic [7:0]  brake;
      logic [7:0]  sum_byte;
      logic [16:0] gain_p;
      logic [16:0] gain_i;
      logic [16:0] gain_d;
   } drive_status_type;

   class command_scoreboard;
      // frame being received
      int unsigned  byte_count;
      logic [7:0]   run_sum;
      logic [7:0]   head [HEAD_LEN];
      logic [7:0]   csum_byte;
      bit           csum_seen;
      // stored command and gains
      logic [7:0]   enable_q;
      int           speed_q;
      int           angle_q;
      logic [7:0]   brake_q;
      logic [7:0]   sum_q;
      int           gain_q [3];

      drive_status_type expected_status [$];
      int unsigned      failures;

      function new();
         byte_count = 0;
         run_sum    = '0;
         foreach (head[k]) head[k] = '0;
         csum_byte  = '0;
         csum_seen  = 0;
         enable_q   = '0;
         speed_q    = 0;
         angle_q    = 0;
         brake_q    = '0;
         sum_q      = '0;
         foreach (gain_q[k]) gain_q[k] = 0;
         failures   = 0;
      endfunction

      local function int word_at(int hi);
         return int'({head[hi], head[hi + 1]}) - WORD_BIAS;
      endfunction

      local function void fault(string msg);
         failures++;
         if (failures <= 10) $display("error at %0t: %s", $realtime, msg);
      endfunction

      local function void check_field(string name, logic [16:0] want, logic [16:0] got);
         if (got !== want) fault($sformatf("%s expected %0h got %0h", name, want, got));
      endfunction

      // one accepted request; a frame end queues the status it must report
      function void absorb_byte(logic [7:0] value, logic last);
         int unsigned      idx;
         int unsigned      dlen;
         logic [1:0]       kind;
         int               a;
         int               t;
         drive_status_type s;
         if (byte_count < FRAME_MAX_DEF) begin
            idx  = byte_count;
            dlen = (idx > 3) ? int'(head[3]) : 255;
            if (idx < HEAD_LEN) head[idx] = value;
            if (idx == 2 || idx == 3 || (idx >= 4 && idx <= dlen + 3)) begin
               run_sum = run_sum + value;
            end else if (idx >= 4 && idx == dlen + 4) begin
               csum_byte = value;
               csum_seen = 1;
            end
            byte_count = idx + 1;
         end
         if (!last) return;

         kind = KIND_NONE;
         if (byte_count >= 5 && head[0] == HDR_BYTE0 && head[1] == HDR_BYTE1 &&
             csum_seen && run_sum == csum_byte) begin
            if (head[2] == ID_DRIVE && byte_count >= HEAD_LEN) begin
               a = word_at(7);
               t = ((a * ANGLE_NUM) / ANGLE_DEN) * ANGLE_MUL;
               if (t > int'(ANGLE_LIM)) t = int'(ANGLE_LIM);
               else if (t < -int'(ANGLE_LIM)) t = -int'(ANGLE_LIM);
               enable_q = head[4];
               speed_q  = word_at(5);
               angle_q  = t;
               brake_q  = head[9];
               sum_q    = head[10];
               kind     = KIND_DRIVE;
            end else if (head[2] == ID_GAIN_SET && byte_count >= HEAD_LEN) begin
               gain_q[0] = word_at(4);
               gain_q[1] = word_at(6);
               gain_q[2] = word_at(8);
               kind      = KIND_GAIN_SET;
            end else if (head[2] == ID_GAIN_READ) begin
               kind = KIND_GAIN_READ;
            end
         end

         byte_count = 0;
         run_sum    = '0;
         csum_seen  = 0;
         csum_byte  = '0;

         s.kind     = kind;
         s.enable   = enable_q;
         s.speed    = speed_q[16:0];
         s.angle    = angle_q[16:0];
         s.brake    = brake_q;
         s.sum_byte = sum_q;
         s.gain_p   = gain_q[0][16:0];
         s.gain_i   = gain_q[1][16:0];
         s.gain_d   = gain_q[2][16:0];
         expected_status.push_back(s);
      endfunction

      function void match_status(drive_status_type got);
         drive_status_type want;
         if (expected_status.size() == 0) begin
            fault($sformatf("response with no frame end waiting, kind %0d", got.kind));
            return;
         end
         want = expected_status.pop_front();
         check_field("packet_kind", 17'(want.kind), 17'(got.kind));
         check_field("drive_enable", 17'(want.enable), 17'(got.enable));
         check_field("target_speed", want.speed, got.speed);
         check_field("target_angle", want.angle, got.angle);
         check_field("brake_value", 17'(want.brake), 17'(got.brake));
         check_field("stored_sum_byte", 17'(want.sum_byte), 17'(got.sum_byte));
         check_field("gain_p", want.gain_p, got.gain_p);
         check_field("gain_i", want.gain_i, got.gain_i);
         check_field("gain_d", want.gain_d, got.gain_d);
      endfunction
   endclass

endpackage

// ----- bench/tb_drive_command_frame_parser_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_drive_command_frame_parser_core
// Streams directed and random command frames into the parser byte by byte,
// with random idle cycles and response stalls, and checks every response
// against the scoreboard's predicted status.
// ----------------------------------------------------------------------------
module tb_drive_command_frame_parser_core;
   import dcfp_pkg::*;
   import dcfp_bench_pkg::*;

   localparam int ITEM_TARGET    = 1300;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 40;
   localparam int MAX_GAP        = 12;
   localparam int MAX_STALL_RUN  = 16;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   logic [7:0]   req_rx_byte;
   logic         req_frame_end;
   logic         rsp_valid;
   logic         rsp_stall;
   logic [1:0]   rsp_packet_kind;
   logic [7:0]   rsp_drive_enable;
   logic [16:0]  rsp_target_speed;
   logic [16:0]  rsp_target_angle;
   logic [7:0]   rsp_brake_value;
   logic [7:0]   rsp_stored_sum_byte;
   logic [16:0]  rsp_gain_p;
   logic [16:0]  rsp_gain_i;
   logic [16:0]  rsp_gain_d;

   command_scoreboard board;
   drive_status_type  got_status;
   logic [7:0]        frame_q [$];
   logic [7:0]        field [6];
   int                bytes_sent;
   int                long_frames;
   int                quiet_cycles;
   int                stall_run;
   int                tx_idle_pct;
   int                rx_idle_pct;

   drive_command_frame_parser_core dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_rx_byte         (req_rx_byte),
      .req_frame_end       (req_frame_end),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_packet_kind     (rsp_packet_kind),
      .rsp_drive_enable    (rsp_drive_enable),
      .rsp_target_speed    (rsp_target_speed),
      .rsp_target_angle    (rsp_target_angle),
      .rsp_brake_value     (rsp_brake_value),
      .rsp_stored_sum_byte (rsp_stored_sum_byte),
      .rsp_gain_p          (rsp_gain_p),
      .rsp_gain_i          (rsp_gain_i),
      .rsp_gain_d          (rsp_gain_d)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // response side stall, runs capped so nothing waits forever
   always @(negedge clock) begin
      if (reset || stall_run >= MAX_STALL_RUN) begin
         rsp_stall <= 1'b0;
         stall_run = 0;
      end else if ($urandom_range(0, 99) < rx_idle_pct) begin
         rsp_stall <= 1'b1;
         stall_run++;
      end else begin
         rsp_stall <= 1'b0;
         stall_run = 0;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got_status = '{rsp_packet_kind, rsp_drive_enable, rsp_target_speed,
                           rsp_target_angle, rsp_brake_value, rsp_stored_sum_byte,
                           rsp_gain_p, rsp_gain_i, rsp_gain_d};
            board.match_status(got_status);
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("drive_command_frame_parser_core regression: fail");
            $finish;
         end
      end
   end

   // sender idles at 13% then 80%, then runs flat out
   function void set_pressure();
      if (bytes_sent < ITEM_TARGET / 3) begin
         tx_idle_pct = 13;
         rx_idle_pct = 80;
      end else if (bytes_sent < 2 * ITEM_TARGET / 3) begin
         tx_idle_pct = 80;
         rx_idle_pct = 13;
      end else begin
         tx_idle_pct = 0;
         rx_idle_pct = 0;
      end
   endfunction

   task automatic send_byte(input logic [7:0] value, input logic last);
      int gap;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(0, 99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
         gap++;
      end
      req_valid     <= 1'b1;
      req_rx_byte   <= value;
      req_frame_end <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.absorb_byte(value, last);
      bytes_sent++;
      set_pressure();
      @(negedge clock);
   endtask

   task automatic send_frame();
      foreach (frame_q[k]) send_byte(frame_q[k], k == frame_q.size() - 1);
   endtask

   // header, id, length, payload and a matching checksum
   task automatic build_frame(input logic [7:0] id, input int len);
      logic [7:0] sum;
      logic [7:0] b;
      frame_q.delete();
      frame_q.push_back(HDR_BYTE0);
      frame_q.push_back(HDR_BYTE1);
      frame_q.push_back(id);
      frame_q.push_back(8'(len));
      sum = id + 8'(len);
      for (int k = 0; k < len; k++) begin
         b = (k < 6) ? field[k] : 8'($urandom_range(0, 255));
         frame_q.push_back(b);
         sum = sum + b;
      end
      frame_q.push_back(sum);
   endtask

   // mostly near the offset so the angle lands both inside and on the clamp
   function logic [15:0] pick_word();
      case ($urandom_range(0, 9))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         2, 3:    return 16'($urandom_range(0, 65535));
         default: return 16'(WORD_BIAS + $urandom_range(0, 3000) - 1500);
      endcase
   endfunction

   task automatic shape_fields(input logic [7:0] id);
      logic [15:0] w;
      foreach (field[k]) field[k] = 8'($urandom_range(0, 255));
      if (id == ID_DRIVE) begin
         if ($urandom_range(0, 3) == 0) field[0] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
         w = pick_word();
         field[1] = w[15:8];
         field[2] = w[7:0];
         w = pick_word();
         field[3] = w[15:8];
         field[4] = w[7:0];
      end else if (id == ID_GAIN_SET) begin
         for (int k = 0; k < 3; k++) begin
            w = pick_word();
            field[2 * k]     = w[15:8];
            field[2 * k + 1] = w[7:0];
         end
      end
   endtask

   task automatic make_random_frame();
      int         r;
      int         len;
      logic [7:0] id;
      r = $urandom_range(0, 99);
      if (r < 30) id = ID_DRIVE;
      else if (r < 55) id = ID_GAIN_SET;
      else if (r < 75) id = ID_GAIN_READ;
      else id = 8'($urandom_range(0, 255));
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 5) : $urandom_range(6, 12);
      shape_fields(id);
      build_frame(id, len);

      r = $urandom_range(0, 99);
      if (r >= 98 && long_frames >= 2) r = 0;
      if (r < 70) begin
         // well formed as built
      end else if (r < 76) begin
         len = $urandom_range(0, 1);
         frame_q[len] = frame_q[len] ^ 8'($urandom_range(1, 255));
      end else if (r < 82) begin
         frame_q[frame_q.size() - 1] = frame_q[frame_q.size() - 1] ^ 8'($urandom_range(1, 255));
      end else if (r < 88) begin
         // frame ends before its checksum
         repeat ($urandom_range(1, frame_q.size() - 1)) void'(frame_q.pop_back());
      end else if (r < 93) begin
         repeat ($urandom_range(1, 4)) frame_q.push_back(8'($urandom_range(0, 255)));
      end else if (r < 98) begin
         frame_q.delete();
         repeat ($urandom_range(1, 15)) frame_q.push_back(8'($urandom_range(0, 255)));
      end else begin
         // long payload, checksum near or past the index limit
         long_frames++;
         build_frame(id, $urandom_range(248, 255));
         repeat ($urandom_range(0, 6)) frame_q.push_back(8'($urandom_range(0, 255)));
      end
   endtask

   initial begin
      board         = new();
      bytes_sent    = 0;
      long_frames   = 0;
      set_pressure();
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_rx_byte   = '0;
      req_frame_end = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // drive command at full enable, top speed, angle on the negative clamp
      field = '{8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00};
      build_frame(ID_DRIVE, 6);
      send_frame();
      // gains at both word extremes and at the offset
      field = '{8'h00, 8'h00, 8'hFF, 8'hFF, 8'h75, 8'h30};
      build_frame(ID_GAIN_SET, 6);
      send_frame();
      // shortest valid frame, gains read with empty payload
      build_frame(ID_GAIN_READ, 0);
      send_frame();
      // a lone byte ends a frame that is too short
      frame_q.delete();
      frame_q.push_back(HDR_BYTE0);
      send_frame();

      while (bytes_sent < ITEM_TARGET) begin
         make_random_frame();
         send_frame();
      end
      req_valid <= 1'b0;

      while (board.expected_status.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.failures == 0 && board.expected_status.size() == 0) begin
         $display("drive_command_frame_parser_core regression: pass");
      end else begin
         $display("drive_command_frame_parser_core regression: fail");
      end
      $finish;
   end

endmodule
